// ===== sv/lzmt_pkg.sv =====
`default_nettype none
package lzmt_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_STRATEGY  = 2'd0,
        REG_QUANT_ONE = 2'd1,
        REG_TABLE_LO  = 2'd2,
        REG_TABLE_HI  = 2'd3
    } t_reg_idx;

    localparam logic [1:0] STRAT_TABLE    = 2'd2;
    localparam logic [1:0] STRAT_EXPLICIT = 2'd3;
    localparam logic [1:0] STRAT_RESET    = 2'd1;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_WRONG_KIND = 2'd1;
    localparam logic [1:0] ERR_PREFIX     = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic       in_bit;
        logic [7:0] in_byte;
    } t_item;

    typedef struct packed {
        logic        need_byte;
        logic        token_done;
        logic [16:0] distance;
        logic [17:0] length;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic [1:0]  strategy;
        logic        quant_one;
        logic [63:0] table_lo;
        logic [63:0] table_hi;
    } t_cfg;

endpackage
`default_nettype wire

// ===== sv/lzmt_fifo.sv =====
`default_nettype none
module lzmt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (rd_en) r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (wr_en && !rd_en)      r_count <= r_count + CNT_W'(1);
            else if (rd_en && !wr_en) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr_ptr] <= i_data;
    end

endmodule
`default_nettype wire

// ===== sv/lzmt_cfg.sv =====
`default_nettype none
module lzmt_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [lzmt_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [lzmt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [lzmt_pkg::CFG_DATA_W-1:0] prdata,
    output lzmt_pkg::t_cfg                      o_cfg
);
    import lzmt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx   = t_reg_idx'(paddr[4:3]);
    assign wr_en = psel && penable && pwrite;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strategy  <= STRAT_RESET;
            r_cfg.quant_one <= 1'b0;
            r_cfg.table_lo  <= '0;
            r_cfg.table_hi  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_STRATEGY:  r_cfg.strategy  <= pwdata[1:0];
                REG_QUANT_ONE: r_cfg.quant_one <= pwdata[0];
                REG_TABLE_LO:  r_cfg.table_lo  <= pwdata;
                REG_TABLE_HI:  r_cfg.table_hi  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_STRATEGY:  prdata = {62'd0, r_cfg.strategy};
            REG_QUANT_ONE: prdata = {63'd0, r_cfg.quant_one};
            REG_TABLE_LO:  prdata = r_cfg.table_lo;
            REG_TABLE_HI:  prdata = r_cfg.table_hi;
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/lzmt_parser.sv =====
`default_nettype none
module lzmt_parser #(
    parameter int MAX_PREFIX   = 16,
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  lzmt_pkg::t_cfg         i_cfg,
    input  lzmt_pkg::t_item        i_item,
    input  wire logic              i_item_valid,
    output logic                   o_item_take,
    output lzmt_pkg::t_result      o_res,
    input  wire logic              i_res_ready
);
    import lzmt_pkg::*;

    localparam int GW = (MAX_PREFIX + 1 > 3) ? MAX_PREFIX + 1 : 3;
    localparam int PW = $clog2(MAX_PREFIX + 2);
    localparam int LW = (GW > 18) ? GW + 1 : 19;
    localparam logic [15:0] OFF_MASK = 16'((32'd1 << OFFSET_WIDTH) - 32'd1);

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_KIND   = 3'd1,
        PH_TABLE  = 3'd2,
        PH_BYTE8  = 3'd3,
        PH_B16LO  = 3'd4,
        PH_B16HI  = 3'd5,
        PH_PREFIX = 3'd6,
        PH_SUFFIX = 3'd7
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [PW-1:0]   r_bit_cnt, n_bit_cnt;
    logic [PW-1:0]   r_zeros, n_zeros;
    logic [GW-1:0]   r_gamma, n_gamma;
    logic [16:0]     r_held, n_held;
    logic [1:0]      r_base, n_base;

    logic            wants_byte;
    logic [2:0]      tidx;
    logic [127:0]    tbl;
    logic [15:0]     entry;
    logic [GW-1:0]   g_shift;
    logic [PW-1:0]   bc_dec;
    logic            bit_in;
    logic [7:0]      byte_in;

    assign o_item_take = i_item_valid && i_res_ready;
    assign bit_in      = i_item.in_bit;
    assign byte_in     = i_item.in_byte;
    assign wants_byte  = (r_phase == PH_BYTE8) || (r_phase == PH_B16LO) ||
                         (r_phase == PH_B16HI);
    assign tidx        = {r_gamma[1:0], bit_in};
    assign tbl         = {i_cfg.table_hi, i_cfg.table_lo};
    assign entry       = tbl[{tidx, 4'b0000} +: 16] & OFF_MASK;
    assign g_shift     = {r_gamma[GW-2:0], bit_in};
    assign bc_dec      = (r_bit_cnt != '0) ? r_bit_cnt - PW'(1) : '0;

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_zeros   = r_zeros;
        n_gamma   = r_gamma;
        n_held    = r_held;
        n_base    = r_base;
        o_res.token_done = 1'b0;
        o_res.distance   = '0;
        o_res.length     = '0;
        o_res.error_code = ERR_NONE;

        if (i_item.req_type != wants_byte) begin
            o_res.error_code = ERR_WRONG_KIND;
            n_phase   = PH_START;
            n_bit_cnt = '0;
            n_zeros   = '0;
            n_gamma   = '0;
            n_held    = '0;
            n_base    = '0;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (i_cfg.strategy == STRAT_TABLE) begin
                        n_gamma   = GW'(bit_in);
                        n_bit_cnt = PW'(1);
                        n_phase   = PH_TABLE;
                    end else if (i_cfg.strategy == STRAT_EXPLICIT) begin
                        n_phase = bit_in ? PH_BYTE8 : PH_B16LO;
                    end else if (bit_in) begin
                        n_phase = PH_KIND;
                    end else begin
                        n_gamma   = '0;
                        n_bit_cnt = '0;
                        n_phase   = PH_TABLE;
                    end
                end
                PH_KIND: n_phase = bit_in ? PH_BYTE8 : PH_B16LO;
                PH_TABLE: begin
                    if (r_bit_cnt >= PW'(2)) begin
                        n_held    = {1'b0, entry};
                        n_base    = i_cfg.quant_one ? 2'd2 : 2'd1;
                        n_zeros   = '0;
                        n_bit_cnt = '0;
                        n_gamma   = '0;
                        n_phase   = PH_PREFIX;
                    end else begin
                        n_gamma   = GW'(tidx);
                        n_bit_cnt = r_bit_cnt + PW'(1);
                    end
                end
                PH_BYTE8: begin
                    n_held    = 17'(byte_in) + 17'd1;
                    n_base    = 2'd2;
                    n_zeros   = '0;
                    n_bit_cnt = '0;
                    n_gamma   = '0;
                    n_phase   = PH_PREFIX;
                end
                PH_B16LO: begin
                    n_held  = 17'(byte_in);
                    n_phase = PH_B16HI;
                end
                PH_B16HI: begin
                    n_held    = 17'({byte_in, r_held[7:0]}) + 17'd1;
                    n_base    = 2'd3;
                    n_zeros   = '0;
                    n_bit_cnt = '0;
                    n_gamma   = '0;
                    n_phase   = PH_PREFIX;
                end
                PH_PREFIX: begin
                    if (!bit_in) begin
                        n_zeros = r_zeros + PW'(1);
                        if (r_zeros >= PW'(MAX_PREFIX)) begin
                            o_res.error_code = ERR_PREFIX;
                            n_phase   = PH_START;
                            n_bit_cnt = '0;
                            n_zeros   = '0;
                            n_gamma   = '0;
                            n_held    = '0;
                            n_base    = '0;
                        end
                    end else if (r_zeros == '0) begin
                        o_res.token_done = 1'b1;
                        o_res.distance   = r_held;
                        o_res.length     = 18'(r_base);
                        n_phase   = PH_START;
                        n_bit_cnt = '0;
                        n_gamma   = '0;
                        n_held    = '0;
                        n_base    = '0;
                    end else begin
                        n_gamma   = GW'(1);
                        n_bit_cnt = r_zeros;
                        n_phase   = PH_SUFFIX;
                    end
                end
                PH_SUFFIX: begin
                    n_gamma   = g_shift;
                    n_bit_cnt = bc_dec;
                    if (bc_dec == '0) begin
                        o_res.token_done = 1'b1;
                        o_res.distance   = r_held;
                        o_res.length     = 18'(LW'(r_base) + LW'(g_shift) - LW'(1));
                        n_phase   = PH_START;
                        n_bit_cnt = '0;
                        n_zeros   = '0;
                        n_gamma   = '0;
                        n_held    = '0;
                        n_base    = '0;
                    end
                end
                default: n_phase = PH_START;
            endcase
        end

        o_res.need_byte = (n_phase == PH_BYTE8) || (n_phase == PH_B16LO) ||
                          (n_phase == PH_B16HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_bit_cnt <= '0;
            r_zeros   <= '0;
            r_gamma   <= '0;
            r_held    <= '0;
            r_base    <= '0;
        end else if (o_item_take) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_zeros   <= n_zeros;
            r_gamma   <= n_gamma;
            r_held    <= n_held;
            r_base    <= n_base;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lz_match_token_parser.sv =====
// LZ match token parser.
// Input channel: an item (i_req_type, i_in_bit, i_in_byte) transfers on a
// rising edge with push high and full low. Items land in a two-entry queue.
// The parser takes one item per cycle from that queue and writes one result
// into a two-entry result queue; results leave on a rising edge with pop
// high and empty low, the oldest on the o_ ports while empty is low.
// Each item is registered in the input queue and its result in the result queue.
// Throughput: one item per cycle while the result queue has room.
// When the receiver stalls, the result queue fills, the parser holds, then
// the input queue fills and full rises; nothing is dropped.
// o_need_byte tells the sender which kind of item is expected next.
// Configuration: APB-style, 64-bit registers at byte addresses 0, 8, 16, 24
// (strategy, quant_one, offset table low, offset table high); pready is
// always high. Write only while the block is idle.
// Reset (synchronous, active low) empties both queues, puts the parser at
// the start of a token and returns all registers to their reset values.
`default_nettype none
module lz_match_token_parser #(
    parameter int MAX_PREFIX   = 16,
    parameter int OFFSET_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lzmt_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [lzmt_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [lzmt_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic                            i_req_type,
    input  wire logic                            i_in_bit,
    input  wire logic [7:0]                      i_in_byte,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic                                 o_need_byte,
    output logic                                 o_token_done,
    output logic      [16:0]                     o_distance,
    output logic      [17:0]                     o_length,
    output logic      [1:0]                      o_error_code
);
    import lzmt_pkg::*;

    t_cfg    cfg;
    t_item   in_item, q_item;
    t_result p_res, q_res;
    logic    q_empty, take, res_full;

    assign pready = 1'b1;
    assign in_item = '{req_type: i_req_type, in_bit: i_in_bit, in_byte: i_in_byte};

    lzmt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    lzmt_fifo #(.WIDTH($bits(t_item)), .DEPTH(2)) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_item),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    lzmt_parser #(.MAX_PREFIX(MAX_PREFIX), .OFFSET_WIDTH(OFFSET_WIDTH)) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (q_item),
        .i_item_valid (!q_empty),
        .o_item_take  (take),
        .o_res        (p_res),
        .i_res_ready  (!res_full)
    );

    lzmt_fifo #(.WIDTH($bits(t_result)), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (p_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_empty (empty)
    );

    assign o_need_byte  = q_res.need_byte;
    assign o_token_done = q_res.token_done;
    assign o_distance   = q_res.distance;
    assign o_length     = q_res.length;
    assign o_error_code = q_res.error_code;

    // a completed token never carries an error and always has a length
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_done) |-> (o_error_code == ERR_NONE && o_length != '0))
        else $error("completed token with error or zero length");

    // no token, no match data
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_token_done) |-> (o_distance == '0 && o_length == '0))
        else $error("match data without completed token");

    // after an error the parser restarts and expects a flag bit
    a_err_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_NONE) |-> !o_need_byte)
        else $error("error result expects a byte");

    // parser only steps when the result queue has room
    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (!res_full && !q_empty))
        else $error("parser stepped without room or item");

endmodule
`default_nettype wire
